// ----- hdl/itae_pkg.sv -----
// Shared types and codes for the indexed array table engine.
`timescale 1ns / 1ps

package itae_pkg;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_DELETE = 2'd1,
        KIND_LINEAR = 2'd2,
        KIND_BINARY = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_BADPOS   = 2'd2,
        STAT_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_READ,
        SEQ_SHIFT,
        SEQ_PUT,
        SEQ_LIN_CHECK,
        SEQ_BIN_CHECK,
        SEQ_FINISH
    } seq_state_t;

    typedef struct packed {
        status_t     status;
        logic [5:0]  found_position;
        logic [6:0]  occupancy;
    } res_t;

endpackage

// ----- hdl/itae_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module itae_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/itae_seq.sv -----
// Operation sequencer: walks the entry RAM for shifts and searches.
`timescale 1ns / 1ps

module itae_seq #(
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  itae_pkg::kind_t          kind_in,
    input  logic [6:0]               position_in,
    input  logic [31:0]              value_in,
    input  logic [6:0]               max_entries,
    input  logic                     res_ready,
    output logic                     idle,
    output logic                     done,
    output itae_pkg::res_t           res,
    output logic                     ram_we,
    output logic [$clog2(DEPTH)-1:0] ram_waddr,
    output logic [31:0]              ram_wdata,
    output logic [$clog2(DEPTH)-1:0] ram_raddr,
    input  logic [31:0]              ram_rdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    // Compare width with headroom for index plus two and for the 7-bit fields.
    localparam int PW = ((CW > 7) ? CW : 7) + 2;

    itae_pkg::seq_state_t state_reg, state_next;
    itae_pkg::kind_t      kind_reg, kind_next;
    itae_pkg::status_t    status_reg, status_next;
    logic [6:0]           pos_reg, pos_next;
    logic [31:0]          val_reg, val_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        idx_reg, idx_next;
    logic [AW-1:0]        found_reg, found_next;
    logic signed [CW:0]   low_reg, low_next;
    logic signed [CW:0]   high_reg, high_next;

    logic [PW-1:0]        cnt_e, idx_e, pos_e, pos_in_e, cap_e, max_e;
    logic                 ins_full, ins_bad, ins_shift_start, del_bad, del_shift_start;
    logic                 ins_more, del_more, lin_more, cnt_zero;
    logic                 rd_hit, rd_less;
    logic [CW+1:0]        mid_sum;
    logic [AW-1:0]        mid;
    logic signed [CW:0]   mid_s, bin_low, bin_high;
    logic                 bin_more;
    logic [CW-1:0]        idx_m1, idx_p1;
    logic [AW+5:0]        found_wide;
    logic [CW+6:0]        occ_wide;

    assign cnt_e    = PW'(count_reg);
    assign idx_e    = PW'(idx_reg);
    assign pos_e    = PW'(pos_reg);
    assign pos_in_e = PW'(position_in);
    assign max_e    = PW'(max_entries);
    assign cap_e    = (max_e < PW'(DEPTH)) ? max_e : PW'(DEPTH);

    assign ins_full        = cnt_e >= cap_e;
    assign ins_bad         = pos_in_e > cnt_e;
    assign ins_shift_start = cnt_e > pos_in_e;
    assign del_bad         = pos_in_e >= cnt_e;
    assign del_shift_start = (pos_in_e + PW'(1)) < cnt_e;
    assign cnt_zero        = count_reg == '0;

    assign ins_more = (idx_e - PW'(1)) > pos_e;
    assign del_more = (idx_e + PW'(2)) < cnt_e;
    assign lin_more = (idx_e + PW'(1)) < cnt_e;

    assign rd_hit  = ram_rdata == val_reg;
    assign rd_less = $signed(ram_rdata) < $signed(val_reg);

    // Both bounds are non-negative whenever a probe is issued.
    assign mid_sum  = (CW+2)'(low_reg[CW-1:0]) + (CW+2)'(high_reg[CW-1:0]);
    assign mid      = mid_sum[AW:1];
    assign mid_s    = (CW+1)'(mid);
    assign bin_low  = rd_less ? (mid_s + (CW+1)'(1)) : low_reg;
    assign bin_high = rd_less ? high_reg : (mid_s - (CW+1)'(1));
    assign bin_more = bin_low <= bin_high;

    assign idx_m1 = idx_reg - CW'(1);
    assign idx_p1 = idx_reg + CW'(1);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            itae_pkg::SEQ_IDLE:
            begin
                if (start)
                begin
                    unique case (kind_in) inside
                        itae_pkg::KIND_INSERT:
                        begin
                            if (ins_full || ins_bad)
                                state_next = itae_pkg::SEQ_FINISH;
                            else if (ins_shift_start)
                                state_next = itae_pkg::SEQ_READ;
                            else
                                state_next = itae_pkg::SEQ_PUT;
                        end
                        itae_pkg::KIND_DELETE:
                        begin
                            if (!del_bad && del_shift_start)
                                state_next = itae_pkg::SEQ_READ;
                            else
                                state_next = itae_pkg::SEQ_FINISH;
                        end
                        itae_pkg::KIND_LINEAR, itae_pkg::KIND_BINARY:
                        begin
                            state_next = cnt_zero ? itae_pkg::SEQ_FINISH : itae_pkg::SEQ_READ;
                        end
                        default:
                            state_next = itae_pkg::SEQ_IDLE;
                    endcase
                end
            end
            itae_pkg::SEQ_READ:
            begin
                unique case (kind_reg) inside
                    itae_pkg::KIND_INSERT, itae_pkg::KIND_DELETE:
                        state_next = itae_pkg::SEQ_SHIFT;
                    itae_pkg::KIND_LINEAR:
                        state_next = itae_pkg::SEQ_LIN_CHECK;
                    default:
                        state_next = itae_pkg::SEQ_BIN_CHECK;
                endcase
            end
            itae_pkg::SEQ_SHIFT:
            begin
                if (kind_reg == itae_pkg::KIND_INSERT)
                    state_next = ins_more ? itae_pkg::SEQ_READ : itae_pkg::SEQ_PUT;
                else
                    state_next = del_more ? itae_pkg::SEQ_READ : itae_pkg::SEQ_FINISH;
            end
            itae_pkg::SEQ_PUT:
                state_next = itae_pkg::SEQ_FINISH;
            itae_pkg::SEQ_LIN_CHECK:
                state_next = (!rd_hit && lin_more) ? itae_pkg::SEQ_READ
                                                   : itae_pkg::SEQ_FINISH;
            itae_pkg::SEQ_BIN_CHECK:
                state_next = (!rd_hit && bin_more) ? itae_pkg::SEQ_READ
                                                   : itae_pkg::SEQ_FINISH;
            itae_pkg::SEQ_FINISH:
            begin
                if (res_ready)
                    state_next = itae_pkg::SEQ_IDLE;
            end
            default:
                state_next = itae_pkg::SEQ_IDLE;
        endcase
    end

    // Outputs toward the RAM and the result register.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg[AW-1:0];
        ram_wdata = ram_rdata;
        ram_raddr = idx_reg[AW-1:0];
        unique case (state_reg)
            itae_pkg::SEQ_READ:
            begin
                case (kind_reg)
                    itae_pkg::KIND_INSERT: ram_raddr = idx_m1[AW-1:0];
                    itae_pkg::KIND_DELETE: ram_raddr = idx_p1[AW-1:0];
                    itae_pkg::KIND_LINEAR: ram_raddr = idx_reg[AW-1:0];
                    default:               ram_raddr = mid;
                endcase
            end
            itae_pkg::SEQ_SHIFT:
            begin
                ram_we = 1'b1;
            end
            itae_pkg::SEQ_PUT:
            begin
                ram_we    = 1'b1;
                ram_waddr = pos_e[AW-1:0];
                ram_wdata = val_reg;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    assign idle       = state_reg == itae_pkg::SEQ_IDLE;
    assign done       = state_reg == itae_pkg::SEQ_FINISH;
    assign found_wide = (AW+6)'(found_reg);
    assign occ_wide   = (CW+7)'(count_reg);
    assign res.status         = status_reg;
    assign res.found_position = found_wide[5:0];
    assign res.occupancy      = occ_wide[6:0];

    // Datapath registers.
    always_comb
    begin
        kind_next   = kind_reg;
        status_next = status_reg;
        pos_next    = pos_reg;
        val_next    = val_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        found_next  = found_reg;
        low_next    = low_reg;
        high_next   = high_reg;
        case (state_reg)
            itae_pkg::SEQ_IDLE:
            begin
                if (start)
                begin
                    kind_next  = kind_in;
                    pos_next   = position_in;
                    val_next   = value_in;
                    found_next = '0;
                    low_next   = '0;
                    high_next  = (CW+1)'(count_reg) - (CW+1)'(1);
                    case (kind_in)
                        itae_pkg::KIND_INSERT:
                        begin
                            idx_next = count_reg;
                            if (ins_full)
                                status_next = itae_pkg::STAT_FULL;
                            else if (ins_bad)
                                status_next = itae_pkg::STAT_BADPOS;
                            else
                                status_next = itae_pkg::STAT_OK;
                        end
                        itae_pkg::KIND_DELETE:
                        begin
                            idx_next = pos_in_e[CW-1:0];
                            if (del_bad)
                            begin
                                status_next = itae_pkg::STAT_BADPOS;
                            end
                            else
                            begin
                                status_next = itae_pkg::STAT_OK;
                                if (!del_shift_start)
                                    count_next = count_reg - CW'(1);
                            end
                        end
                        default:
                        begin
                            idx_next    = '0;
                            status_next = itae_pkg::STAT_NOTFOUND;
                        end
                    endcase
                end
            end
            itae_pkg::SEQ_SHIFT:
            begin
                if (kind_reg == itae_pkg::KIND_INSERT)
                begin
                    idx_next = idx_m1;
                end
                else
                begin
                    idx_next = idx_p1;
                    if (!del_more)
                        count_next = count_reg - CW'(1);
                end
            end
            itae_pkg::SEQ_PUT:
            begin
                count_next = count_reg + CW'(1);
            end
            itae_pkg::SEQ_LIN_CHECK:
            begin
                if (rd_hit)
                begin
                    status_next = itae_pkg::STAT_OK;
                    found_next  = idx_reg[AW-1:0];
                end
                else
                begin
                    idx_next = idx_p1;
                end
            end
            itae_pkg::SEQ_BIN_CHECK:
            begin
                if (rd_hit)
                begin
                    status_next = itae_pkg::STAT_OK;
                    found_next  = mid;
                end
                else
                begin
                    low_next  = bin_low;
                    high_next = bin_high;
                end
            end
            default:
            begin
                idx_next = idx_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= itae_pkg::SEQ_IDLE;
            kind_reg   <= itae_pkg::KIND_INSERT;
            status_reg <= itae_pkg::STAT_OK;
            count_reg  <= '0;
            idx_reg    <= '0;
            found_reg  <= '0;
            low_reg    <= '0;
            high_reg   <= '0;
            pos_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            kind_reg   <= kind_next;
            status_reg <= status_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            found_reg  <= found_next;
            low_reg    <= low_next;
            high_reg   <= high_next;
            pos_reg    <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

// ----- hdl/indexed_array_table_engine_core.sv -----
// One request is handled at a time; every entry moved or compared takes a registered RAM
// read followed by the write back or the compare, and output stalls hold up completion.
// Reset clears the entry count, the capacity register (to 64) and all handshakes;
// the entry RAM itself is not cleared, since only written positions are ever read.
`timescale 1ns / 1ps

module indexed_array_table_engine_core #(
    parameter int DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [6:0]  position,
    input  logic [31:0] item_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [5:0]  found_position,
    output logic [6:0]  occupancy,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data
);

    localparam int AW = $clog2(DEPTH);

    logic [6:0]      max_entries_reg;
    logic            out_valid_reg;
    itae_pkg::res_t  res_reg;
    itae_pkg::res_t  seq_res;
    logic            seq_idle, seq_done, out_free, load;
    logic            ram_we;
    logic [AW-1:0]   ram_waddr, ram_raddr;
    logic [31:0]     ram_wdata, ram_rdata;

    assign cfg_ready = 1'b1;
    assign in_stall  = !seq_idle;
    assign out_free  = !out_valid_reg || !out_stall;
    assign load      = seq_done && out_free;

    itae_seq #(
        .DEPTH(DEPTH)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (in_valid && seq_idle),
        .kind_in     (itae_pkg::kind_t'(kind)),
        .position_in (position),
        .value_in    (item_value),
        .max_entries (max_entries_reg),
        .res_ready   (out_free),
        .idle        (seq_idle),
        .done        (seq_done),
        .res         (seq_res),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata)
    );

    itae_ram #(
        .WIDTH(32),
        .DEPTH(DEPTH)
    ) u_entries (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_entries_reg <= 7'd64;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                max_entries_reg <= cfg_data;
            if (load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= seq_res;
    end

    assign out_valid      = out_valid_reg;
    assign status         = res_reg.status;
    assign found_position = res_reg.found_position;
    assign occupancy      = res_reg.occupancy;

`ifndef NO_ASSERTIONS
    // An accepted request always takes the sequencer out of idle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("request accepted but sequencer stayed idle");

    // Only a successful search reports a nonzero position.
    a_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != itae_pkg::STAT_OK)) |-> (found_position == 6'd0))
        else $error("nonzero position on a failed request");

    // A fresh result appears only after the sequencer was busy.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result produced without a request in flight");
`endif

endmodule

// ----- dv/tb.sv -----
// Self-checking bench for the ordered table engine: directed and random requests checked against a predictor.
`timescale 1ns / 1ps

module tb;

    localparam int TABLE_DEPTH  = 64;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 150;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 86;

    typedef struct {
        bit              is_cfg;
        itae_pkg::kind_t op;
        logic [6:0]      pos;
        logic [31:0]     value;
        logic [6:0]      cap;
    } table_op_t;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            in_valid = 1'b0;
    logic            in_stall;
    itae_pkg::kind_t kind = itae_pkg::KIND_INSERT;
    logic [6:0]      position = '0;
    logic [31:0]     item_value = '0;
    logic            out_valid;
    logic            out_stall = 1'b0;
    logic [1:0]      status;
    logic [5:0]      found_position;
    logic [6:0]      occupancy;
    logic            cfg_valid = 1'b0;
    logic            cfg_ready;
    logic [6:0]      cfg_data = 7'd64;

    table_op_t       request_q[$];
    itae_pkg::res_t  response_q[$];

    // Predictor state.
    logic [31:0] model_words [0:TABLE_DEPTH-1];
    int          model_count = 0;
    int          model_cap = 64;

    // Stimulus planning state: tracks table contents so inserts can keep it sorted.
    logic [31:0] plan_vals[$];
    int          plan_cap = 64;

    int          error_count = 0;
    int          cycle_count = 0;
    int          send_gap = 0;
    int          send_calm = 0;
    int          stall_left = 0;
    int          stall_calm = 0;
    logic        tail_mode = 1'b0;

    indexed_array_table_engine_core #(
        .DEPTH(TABLE_DEPTH)
    ) uut (
        .*
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic compute_table_response(input itae_pkg::kind_t op, input logic [6:0] pos_in,
                                          input logic [31:0] value,
                                          output itae_pkg::res_t res);
        int                limit;
        int                p;
        int                i;
        int                lo;
        int                hi;
        int                mid;
        int                hit;
        itae_pkg::status_t st;
        st = itae_pkg::STAT_OK;
        hit = 0;
        p = pos_in;
        limit = (model_cap < TABLE_DEPTH) ? model_cap : TABLE_DEPTH;
        case (op)
            itae_pkg::KIND_INSERT:
            begin
                // The full check wins over the position check.
                if (model_count >= limit)
                    st = itae_pkg::STAT_FULL;
                else if (p > model_count)
                    st = itae_pkg::STAT_BADPOS;
                else
                begin
                    for (i = model_count; i > p; i--)
                        model_words[i] = model_words[i - 1];
                    model_words[p] = value;
                    model_count++;
                end
            end
            itae_pkg::KIND_DELETE:
            begin
                if (p >= model_count)
                    st = itae_pkg::STAT_BADPOS;
                else
                begin
                    for (i = p; i + 1 < model_count; i++)
                        model_words[i] = model_words[i + 1];
                    model_count--;
                end
            end
            itae_pkg::KIND_LINEAR:
            begin
                st = itae_pkg::STAT_NOTFOUND;
                for (i = 0; i < model_count; i++)
                begin
                    if (model_words[i] == value)
                    begin
                        st = itae_pkg::STAT_OK;
                        hit = i;
                        break;
                    end
                end
            end
            default:
            begin
                st = itae_pkg::STAT_NOTFOUND;
                lo = 0;
                hi = model_count - 1;
                while (lo <= hi)
                begin
                    mid = (lo + hi) / 2;
                    if (model_words[mid] == value)
                    begin
                        st = itae_pkg::STAT_OK;
                        hit = mid;
                        break;
                    end
                    else if ($signed(model_words[mid]) < $signed(value))
                        lo = mid + 1;
                    else
                        hi = mid - 1;
                end
            end
        endcase
        res.status = st;
        res.found_position = 6'(hit);
        res.occupancy = 7'(model_count);
    endtask

    task automatic queue_request(input itae_pkg::kind_t op, input int pos,
                                 input logic [31:0] value);
        table_op_t r;
        int        limit;
        r.is_cfg = 1'b0;
        r.op = op;
        r.pos = 7'(pos);
        r.value = value;
        r.cap = '0;
        request_q.push_back(r);
        limit = (plan_cap < TABLE_DEPTH) ? plan_cap : TABLE_DEPTH;
        if (op == itae_pkg::KIND_INSERT && plan_vals.size() < limit && pos <= plan_vals.size())
            plan_vals.insert(pos, value);
        else if (op == itae_pkg::KIND_DELETE && pos < plan_vals.size())
            plan_vals.delete(pos);
    endtask

    task automatic queue_capacity(input int cap);
        table_op_t r;
        r.is_cfg = 1'b1;
        r.op = itae_pkg::KIND_INSERT;
        r.pos = '0;
        r.value = '0;
        r.cap = 7'(cap);
        request_q.push_back(r);
        plan_cap = cap;
    endtask

    // Small values give plenty of duplicates and search hits; the extremes test signed order.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(9)) inside
            0: return 32'h8000_0000 + $urandom_range(3);
            1: return 32'h7fff_fffc + $urandom_range(3);
            [2:3]: return $urandom_range(16) - 8;
            default: return $urandom;
        endcase
    endfunction

    function automatic int sorted_slot(input logic [31:0] value);
        int i;
        for (i = 0; i < plan_vals.size(); i++)
            if ($signed(plan_vals[i]) >= $signed(value))
                return i;
        return plan_vals.size();
    endfunction

    initial
    begin : stimulus
        int          phase_cap [PHASES];
        int          phase_ins [PHASES];
        int          phase_del [PHASES];
        int          p;
        int          n;
        int          roll;
        int          fill;
        int          sel;
        logic [31:0] v;

        // Empty table, out-of-range positions, then signed extremes in order.
        queue_request(itae_pkg::KIND_DELETE, 0, 32'h0);
        queue_request(itae_pkg::KIND_LINEAR, 5, 32'h0);
        queue_request(itae_pkg::KIND_BINARY, 64, 32'h0);
        queue_request(itae_pkg::KIND_INSERT, 1, 32'h1);
        queue_request(itae_pkg::KIND_INSERT, 64, 32'hffff_ffff);
        queue_request(itae_pkg::KIND_INSERT, 0, 32'h8000_0000);
        queue_request(itae_pkg::KIND_INSERT, 1, 32'h7fff_ffff);
        queue_request(itae_pkg::KIND_INSERT, 1, 32'h0000_0000);
        queue_request(itae_pkg::KIND_INSERT, 1, 32'hffff_ffff);
        queue_request(itae_pkg::KIND_BINARY, 0, 32'h8000_0000);
        queue_request(itae_pkg::KIND_BINARY, 0, 32'h7fff_ffff);
        queue_request(itae_pkg::KIND_BINARY, 0, 32'hffff_ffff);
        queue_request(itae_pkg::KIND_BINARY, 0, 32'h0000_0000);
        queue_request(itae_pkg::KIND_BINARY, 0, 32'h0000_0005);
        queue_request(itae_pkg::KIND_LINEAR, 0, 32'h7fff_ffff);
        queue_request(itae_pkg::KIND_LINEAR, 0, 32'h0000_3039);
        queue_request(itae_pkg::KIND_INSERT, 4, 32'h7fff_ffff);
        queue_request(itae_pkg::KIND_LINEAR, 0, 32'h7fff_ffff);
        queue_request(itae_pkg::KIND_DELETE, 5, 32'h0);
        queue_request(itae_pkg::KIND_DELETE, 4, 32'h0);
        queue_request(itae_pkg::KIND_DELETE, 0, 32'h0);
        // Out of order on purpose, so binary search sees an unsorted table.
        queue_request(itae_pkg::KIND_INSERT, 0, 32'h0000_0064);
        queue_request(itae_pkg::KIND_BINARY, 0, 32'h0000_0064);
        queue_request(itae_pkg::KIND_DELETE, 0, 32'h0);

        // Capacity sweep: fill toward the limit, squeeze it down to zero, then mix.
        phase_cap = '{64, 127, 1, 0, 2, $urandom_range(64, 1), 64, $urandom_range(64, 1)};
        phase_ins = '{55, 60, 30, 30, 40, 45, 40, 40};
        phase_del = '{10, 10, 45, 45, 30, 25, 30, 30};
        for (p = 0; p < PHASES; p++)
        begin
            queue_capacity(phase_cap[p]);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                roll = $urandom_range(99);
                fill = plan_vals.size();
                if (roll < phase_ins[p])
                begin
                    v = pick_value();
                    sel = $urandom_range(19);
                    if (sel < 17)
                        queue_request(itae_pkg::KIND_INSERT, sorted_slot(v), v);
                    else if (sel < 19 || fill == TABLE_DEPTH)
                        queue_request(itae_pkg::KIND_INSERT, $urandom_range(fill), v);
                    else
                        queue_request(itae_pkg::KIND_INSERT,
                                      $urandom_range(TABLE_DEPTH, fill + 1), v);
                end
                else if (roll < phase_ins[p] + phase_del[p])
                begin
                    if (fill > 0 && $urandom_range(9) != 0)
                        queue_request(itae_pkg::KIND_DELETE, $urandom_range(fill - 1), $urandom);
                    else
                        queue_request(itae_pkg::KIND_DELETE,
                                      $urandom_range(TABLE_DEPTH, fill), $urandom);
                end
                else
                begin
                    if (fill > 0 && $urandom_range(9) < 7)
                        v = plan_vals[$urandom_range(fill - 1)];
                    else
                        v = pick_value();
                    queue_request((roll % 2 == 1) ? itae_pkg::KIND_BINARY : itae_pkg::KIND_LINEAR,
                                  $urandom_range(TABLE_DEPTH), v);
                end
            end
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Sample at the falling edge so the driver's updates have settled.
        @(negedge clk);
        while (request_q.size() != 0 || in_valid || cfg_valid)
            @(negedge clk);
        while (response_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (error_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    always @(posedge clk or negedge rst_n)
    begin : request_driver
        table_op_t      head;
        itae_pkg::res_t answer;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            cfg_valid <= 1'b0;
            send_gap <= 0;
            send_calm <= 0;
            tail_mode <= 1'b0;
        end
        else
        begin
            tail_mode <= (request_q.size() < 60);
            if (in_valid && !in_stall)
            begin
                compute_table_response(kind, position, item_value, answer);
                response_q.push_back(answer);
            end
            if (cfg_valid && cfg_ready)
                model_cap = cfg_data;

            if (!((in_valid && in_stall) || (cfg_valid && !cfg_ready)))
            begin
                if (send_gap > 0)
                begin
                    in_valid <= 1'b0;
                    cfg_valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (request_q.size() == 0)
                begin
                    in_valid <= 1'b0;
                    cfg_valid <= 1'b0;
                end
                else if (request_q[0].is_cfg)
                begin
                    // The capacity only changes once every request has been answered.
                    in_valid <= 1'b0;
                    if (response_q.size() == 0)
                    begin
                        head = request_q.pop_front();
                        cfg_valid <= 1'b1;
                        cfg_data <= head.cap;
                    end
                    else
                        cfg_valid <= 1'b0;
                end
                else
                begin
                    cfg_valid <= 1'b0;
                    if (in_valid && !tail_mode && send_calm == 0 && $urandom_range(3) == 0)
                    begin
                        in_valid <= 1'b0;
                        send_gap <= $urandom_range(11);
                    end
                    else
                    begin
                        head = request_q.pop_front();
                        in_valid <= 1'b1;
                        kind <= head.op;
                        position <= head.pos;
                        item_value <= head.value;
                        if (send_calm > 0)
                            send_calm <= send_calm - 1;
                        else if ($urandom_range(29) == 0)
                            send_calm <= $urandom_range(60, 20);
                    end
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left <= 0;
            stall_calm <= 0;
        end
        else if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (stall_calm > 0)
        begin
            out_stall <= 1'b0;
            stall_calm <= stall_calm - 1;
        end
        else if (!tail_mode && $urandom_range(5) == 0)
        begin
            out_stall <= 1'b1;
            stall_left <= $urandom_range(11);
        end
        else
        begin
            out_stall <= 1'b0;
            if ($urandom_range(39) == 0)
                stall_calm <= $urandom_range(200, 50);
        end
    end

    always @(posedge clk)
    begin : response_checker
        itae_pkg::res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (response_q.size() == 0)
            begin
                $error("status: response with no request pending, got %0d", status);
                error_count++;
            end
            else
            begin
                want = response_q.pop_front();
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    error_count++;
                end
                if (found_position !== want.found_position)
                begin
                    $error("found_position: expected %0d, got %0d",
                           want.found_position, found_position);
                    error_count++;
                end
                if (occupancy !== want.occupancy)
                begin
                    $error("occupancy: expected %0d, got %0d", want.occupancy, occupancy);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: done, errors");
            $finish;
        end
    end

endmodule
